// ===== hw/rtl/ksib_pkg.sv =====
// ----------------------------------------------------------------------------
// ksib_pkg
// Shared types and codes for the two-level search index builder: the request
// and result payloads, command and result-kind codes, and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package ksib_pkg;

   localparam int MULT_W = 5;
   localparam int SLOT_W = 4;
   localparam int CFG_W  = 9;

   // Command codes of a request.
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_LEVEL0 = 2'd1;
   localparam logic [1:0] CMD_REGION = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_LEVEL0 = 2'd0;
   localparam logic [1:0] KIND_LEVEL1 = 2'd1;
   localparam logic [1:0] KIND_BASE   = 2'd2;

   // Register index taken from the word address of the configuration port.
   localparam logic REG_SEGMENT_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [8:0]  knot_index;
      logic [31:0] knot_value;
      logic [3:0]  region;
   } req_type;

   typedef struct packed {
      logic [1:0]  table_kind;
      logic [3:0]  slot;
      logic [31:0] value;
      logic        last;
   } rsp_type;

   // Work issued into the datapath pipeline.
   typedef enum logic [2:0] {
      OP_PRE_S,
      OP_PRE_E,
      OP_SEP0,
      OP_SEP1,
      OP_BASE
   } op_type;

   typedef struct packed {
      logic              load_en;
      logic              clear_bounds;
      logic              issue;
      op_type            op;
      logic [MULT_W-1:0] mult;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } dp_cmd_type;

   typedef struct packed {
      logic bounds_ready;
      logic pipe_idle;
   } dp_status_type;

endpackage

// ===== hw/rtl/ksib_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksib_ctrl
// Command sequencer: accepts requests, issues the region bound divisions and
// then one separator or base computation per cycle into the datapath.
// ----------------------------------------------------------------------------
module ksib_ctrl #(
   parameter int KEYS_PER_NODE  = 8,
   parameter int FANOUT         = 9,
   parameter int LEVEL1_REGIONS = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ksib_pkg::req_type      req_data,
   input  ksib_pkg::dp_status_type status,
   output ksib_pkg::dp_cmd_type   dp_cmd
);
   import ksib_pkg::*;

   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] LAST_L0  = CNT_W'(KEYS_PER_NODE - 1);
   localparam logic [CNT_W-1:0] SEP_N    = CNT_W'(KEYS_PER_NODE);
   localparam logic [CNT_W-1:0] LAST_REG = CNT_W'(KEYS_PER_NODE + FANOUT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PRE   = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_ISSUE = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [3:0]       region_ff, region_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic [CNT_W-1:0] base_idx;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign base_idx = cnt_ff - SEP_N;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      region_in = region_ff;
      cnt_in    = cnt_ff;

      dp_cmd              = '0;
      dp_cmd.op           = OP_SEP0;
      dp_cmd.load_en      = accept && (req_data.cmd == CMD_LOAD);
      dp_cmd.clear_bounds = accept;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.cmd;
               region_in = req_data.region;
               cnt_in    = '0;
               if (req_data.cmd == CMD_LEVEL0) begin
                  state_in = ST_ISSUE;
               end else if (req_data.cmd == CMD_REGION &&
                            {1'b0, req_data.region} < 5'(LEVEL1_REGIONS)) begin
                  state_in = ST_PRE;
               end
            end
         end
         ST_PRE: begin
            // Region start first, then region end.
            dp_cmd.issue = 1'b1;
            if (cnt_ff == '0) begin
               dp_cmd.op   = OP_PRE_S;
               dp_cmd.mult = {1'b0, region_ff};
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               dp_cmd.op   = OP_PRE_E;
               dp_cmd.mult = {1'b0, region_ff} + 5'd1;
               cnt_in      = '0;
               state_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.bounds_ready) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            dp_cmd.issue = 1'b1;
            if (cmd_ff == CMD_LEVEL0) begin
               dp_cmd.op   = OP_SEP0;
               dp_cmd.slot = SLOT_W'(cnt_ff);
               dp_cmd.mult = MULT_W'(cnt_ff + 1'b1);
               dp_cmd.last = (cnt_ff == LAST_L0);
            end else if (cnt_ff < SEP_N) begin
               dp_cmd.op   = OP_SEP1;
               dp_cmd.slot = SLOT_W'(cnt_ff);
               dp_cmd.mult = MULT_W'(cnt_ff + 1'b1);
            end else begin
               dp_cmd.op   = OP_BASE;
               dp_cmd.slot = SLOT_W'(base_idx);
               dp_cmd.mult = MULT_W'(base_idx);
               dp_cmd.last = (cnt_ff == LAST_REG);
            end
            if (dp_cmd.last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff    <= cmd_in;
      region_ff <= region_in;
   end

endmodule

// ===== hw/rtl/ksib_datapath.sv =====
// ----------------------------------------------------------------------------
// ksib_datapath
// Knot memory and the index pipeline: multiply, divide by the fanout through a
// reciprocal, offset and clamp, knot read, and result formatting.
// ----------------------------------------------------------------------------
module ksib_datapath #(
   parameter int SEG_CAPACITY = 256,
   parameter int FANOUT       = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ksib_pkg::dp_cmd_type    dp_cmd,
   input  ksib_pkg::req_type       req_data,
   input  logic [8:0]              segment_count,
   output ksib_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output ksib_pkg::rsp_type       rsp_data
);
   import ksib_pkg::*;

   localparam int NW    = $clog2(SEG_CAPACITY + 1);
   localparam int DEPTH = SEG_CAPACITY + 1;
   localparam int XW    = NW + MULT_W;
   localparam int SHIFT = XW + 4;
   localparam int RW    = SHIFT;
   localparam int PW    = XW + RW;
   // Rounded-up reciprocal; exact quotient for every numerator below 2**XW.
   localparam logic [RW-1:0] RECIP = RW'(((2 ** SHIFT) + FANOUT - 1) / FANOUT);

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } tag_type;

   logic [31:0]   mem [DEPTH];

   logic [NW-1:0] n;
   logic [NW-1:0] b_sel;
   logic [XW-1:0] x1_ff, x1_in;
   logic [PW-1:0] p2_ff, p2_in;
   logic [XW:0]   seg3_ff, seg3_in;
   logic [NW-1:0] seg4_ff;
   logic [31:0]   rd_ff;
   tag_type       tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag1_in;
   logic [XW-1:0] s_ff;
   logic [NW-1:0] z_ff;
   logic          bounds_ready_ff;

   logic [XW-1:0] quot;
   logic [XW:0]   base_sum;
   logic [XW:0]   limit;
   logic          offset_op;
   logic          knot_op3;

   always_comb begin
      if (segment_count == 9'd0) begin
         n = NW'(1);
      end else if (segment_count > 9'(SEG_CAPACITY)) begin
         n = NW'(SEG_CAPACITY);
      end else begin
         n = segment_count[NW-1:0];
      end
   end

   // Stage 1: numerator.
   assign b_sel = (dp_cmd.op == OP_SEP1 || dp_cmd.op == OP_BASE) ? z_ff : n;
   assign x1_in = XW'(dp_cmd.mult) * XW'(b_sel);
   assign tag1_in = '{valid: dp_cmd.issue, op: dp_cmd.op, slot: dp_cmd.slot,
                      last: dp_cmd.last};

   // Stage 2: multiply by the reciprocal.
   assign p2_in = PW'(x1_ff) * PW'(RECIP);

   // Stage 3: quotient, region offset and clamp.
   assign quot      = p2_ff[SHIFT +: XW];
   assign offset_op = (tag2_ff.op == OP_SEP1) || (tag2_ff.op == OP_BASE);
   assign base_sum  = (offset_op ? {1'b0, s_ff} : '0) + {1'b0, quot};
   assign limit     = (tag2_ff.op == OP_BASE) ? (XW+1)'(n - 1'b1) : (XW+1)'(n);

   always_comb begin
      seg3_in = base_sum;
      if (tag2_ff.op != OP_PRE_S && tag2_ff.op != OP_PRE_E && base_sum > limit) begin
         seg3_in = limit;
      end
   end

   assign knot_op3 = (tag3_ff.op == OP_SEP0) || (tag3_ff.op == OP_SEP1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff         <= '0;
         tag2_ff         <= '0;
         tag3_ff         <= '0;
         tag4_ff         <= '0;
         bounds_ready_ff <= 1'b0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         if (dp_cmd.clear_bounds) begin
            bounds_ready_ff <= 1'b0;
         end else if (tag3_ff.valid && tag3_ff.op == OP_PRE_E) begin
            bounds_ready_ff <= 1'b1;
         end
      end
      x1_ff   <= x1_in;
      p2_ff   <= p2_in;
      seg3_ff <= seg3_in;
      seg4_ff <= seg3_ff[NW-1:0];
      // The region start lands in the cycle before the region end.
      if (tag3_ff.valid && tag3_ff.op == OP_PRE_S) begin
         s_ff <= seg3_ff[XW-1:0];
      end
      if (tag3_ff.valid && tag3_ff.op == OP_PRE_E) begin
         z_ff <= NW'(seg3_ff[XW-1:0] - s_ff);
      end
   end

   // Knot memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (dp_cmd.load_en && req_data.knot_index <= 9'(SEG_CAPACITY)) begin
         mem[req_data.knot_index[NW-1:0]] <= req_data.knot_value;
      end
      if (tag3_ff.valid && knot_op3) begin
         rd_ff <= mem[seg3_ff[NW-1:0]];
      end
   end

   assign rsp_valid = tag4_ff.valid && tag4_ff.op != OP_PRE_S && tag4_ff.op != OP_PRE_E;

   always_comb begin
      rsp_data.slot  = tag4_ff.slot;
      rsp_data.last  = tag4_ff.last;
      rsp_data.value = rd_ff;
      unique case (tag4_ff.op)
         OP_SEP0: rsp_data.table_kind = KIND_LEVEL0;
         OP_SEP1: rsp_data.table_kind = KIND_LEVEL1;
         OP_BASE: begin
            rsp_data.table_kind = KIND_BASE;
            rsp_data.value      = 32'(seg4_ff);
         end
         default: rsp_data.table_kind = KIND_LEVEL0;
      endcase
   end

   assign status.bounds_ready = bounds_ready_ff;
   assign status.pipe_idle    = !(tag1_ff.valid || tag2_ff.valid ||
                                  tag3_ff.valid || tag4_ff.valid);

endmodule

// ===== hw/rtl/kary_spline_index_build.sv =====
// ----------------------------------------------------------------------------
// kary_spline_index_build
// Two-level k-ary search index builder over a table of spline knot positions.
// ----------------------------------------------------------------------------
// A load command is taken while busy stays low. A level-0 command or a region
// command keeps busy high until its last result has left the pipeline: the
// results come out one per cycle, each through a four-stage pipeline of
// multiply, reciprocal multiply, offset and clamp, and a registered knot
// memory read, and a region command first runs its two region bound
// divisions through the same pipeline. Results are shown on rsp_valid for a
// single cycle each and cannot be held off, so the receiver must take every
// transfer as it comes. A region command for a region beyond the last, and
// the unused command code, produce no result.
// ----------------------------------------------------------------------------
module kary_spline_index_build #(
   parameter int SEG_CAPACITY   = 256,
   parameter int KEYS_PER_NODE  = 8,
   parameter int FANOUT         = 9,
   parameter int LEVEL1_REGIONS = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ksib_pkg::req_type req_data,
   output logic              rsp_valid,
   output ksib_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ksib_pkg::*;

   logic [CFG_W-1:0] segment_count_ff, segment_count_in;
   logic             csr_sel;
   dp_cmd_type       dp_cmd;
   dp_status_type    dp_status;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[2] == REG_SEGMENT_COUNT);
   assign prdata  = csr_sel ? 32'(segment_count_ff) : '0;

   always_comb begin
      segment_count_in = segment_count_ff;
      if (psel && penable && pwrite && pready && csr_sel) begin
         segment_count_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= CFG_W'(1);
      end else begin
         segment_count_ff <= segment_count_in;
      end
   end

   ksib_ctrl #(
      .KEYS_PER_NODE  (KEYS_PER_NODE),
      .FANOUT         (FANOUT),
      .LEVEL1_REGIONS (LEVEL1_REGIONS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .status   (dp_status),
      .dp_cmd   (dp_cmd)
   );

   ksib_datapath #(
      .SEG_CAPACITY (SEG_CAPACITY),
      .FANOUT       (FANOUT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .req_data      (req_data),
      .segment_count (segment_count_ff),
      .status        (dp_status),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

endmodule
